FILE: hdl/weighted_queue_resource_issue_macros.svh
// ----------------------------------------------------------------------------
// weighted_queue_resource_issue_macros.svh
// assertion macros shared by the weighted queue design
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_QUEUE_RESOURCE_ISSUE_MACROS_SVH
`define WEIGHTED_QUEUE_RESOURCE_ISSUE_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define WQRI_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("weighted queue check failed");

// next-cycle implication, skipped while reset is high
`define WQRI_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("weighted queue check failed");

`endif

FILE: hdl/wqri_pkg.sv
// ----------------------------------------------------------------------------
// wqri_pkg
// types and constants shared by the weighted queue cells and the top level
// ----------------------------------------------------------------------------
package wqri_pkg;

  localparam int TAG_W    = 8;
  localparam int WEIGHT_W = 16;
  localparam int MASK_W   = 5;
  localparam int PHASE_W  = 4;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 5;

  // one queue entry
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [WEIGHT_W-1:0] weight;
    logic [MASK_W-1:0]   mask;
    logic                light;
    logic [PHASE_W-1:0]  total;
    logic [PHASE_W-1:0]  phase;
  } slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              fb;
    logic              flush;
    logic [MASK_W-1:0] amask;
    slot_t             item;
  } cmd_t;

  // signals handed from a cell to its right neighbor
  typedef struct packed {
    logic              ge;
    logic              seen;
    logic              rm;
    logic              run;
    logic [MASK_W-1:0] used;
  } chain_t;

  // per-cell status collected by the top level
  typedef struct packed {
    logic              load;
    logic              hit;
    logic              ok;
    logic              done;
    logic              run;
    logic [MASK_W-1:0] mask;
  } flags_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED    = 3'd0,
    STAT_FULL        = 3'd1,
    STAT_ADVANCED    = 3'd2,
    STAT_COMPLETED   = 3'd3,
    STAT_WRONG_PHASE = 3'd4,
    STAT_ABSENT      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN
  } state_t;

endpackage

FILE: hdl/weighted_queue_resource_issue.sv
// ----------------------------------------------------------------------------
// weighted_queue_resource_issue
// weighted task queue with actuator conflict scan
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one transaction per task event. mode 0
// inserts a task ordered by descending weight (equal weights keep arrival
// order); mode 1 reports a phase for the first queued task with that tag.
// Output channel (out_valid / out_stall): exactly one result transaction per
// input transaction, in order: status, insert position, the length of the
// leading conflict-free run, the owning position of each actuator, and
// queue_empty after the event.
// Flow: the accepting edge moves the fsm to the update state (one pass
// through the cell chain), then to the scan state, from which the result
// register loads. A new transaction is taken the cycle after the result
// register loads; in_stall stays high through the update and scan states.
// The result register lets the next transaction be accepted while a result
// is still stalled; a scan finishing into a full output register waits in
// the scan state until out_stall drops.
// Reset empties the queue at once; slot contents need no clearing.
// ----------------------------------------------------------------------------
`include "weighted_queue_resource_issue_macros.svh"

module weighted_queue_resource_issue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int NUM_ACTUATORS = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [wqri_pkg::TAG_W-1:0]      tag,
  input  logic [wqri_pkg::WEIGHT_W-1:0]   weight,
  input  logic [wqri_pkg::MASK_W-1:0]     resource_mask,
  input  logic                            light,
  input  logic [wqri_pkg::PHASE_W-1:0]    total_phases,
  input  logic [wqri_pkg::PHASE_W-1:0]    phase,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wqri_pkg::STATUS_W-1:0]   status,
  output logic [wqri_pkg::POS_W-1:0]      insert_position,
  output logic [wqri_pkg::POS_W-1:0]      parallel_count,
  output logic [wqri_pkg::POS_W-1:0]      owner_gaze,
  output logic [wqri_pkg::POS_W-1:0]      owner_emotion,
  output logic [wqri_pkg::POS_W-1:0]      owner_voice,
  output logic [wqri_pkg::POS_W-1:0]      owner_manipulator,
  output logic [wqri_pkg::POS_W-1:0]      owner_mover,
  output logic                            queue_empty
);
  import wqri_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [MASK_W-1:0] AMASK =
    (NUM_ACTUATORS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_ACTUATORS) - 1);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  slot_t              item;
  logic               item_mode;
  status_t            pend_status;
  logic [POS_W-1:0]   pend_pos;
  logic               upd;
  logic               load_out;
  logic               take_in;
  logic               flush;
  logic               full;
  cmd_t               cmd;

  slot_t              slots  [QUEUE_DEPTH];
  chain_t             chains [QUEUE_DEPTH+1];
  flags_t             flags  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] ld;

  logic               any_hit;
  logic               any_ok;
  logic               any_done;
  logic [POS_W-1:0]   ins_pos;
  logic [POS_W-1:0]   par_cnt;
  logic [POS_W-1:0]   owner_or  [MASK_W];
  logic [MASK_W-1:0]  owner_any;
  logic [POS_W-1:0]   owner     [MASK_W];

  // fsm next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_UPDATE;
      S_UPDATE: state_next = S_SCAN;
      S_SCAN:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall = (state != S_IDLE);
    upd      = (state == S_UPDATE);
    load_out = (state == S_SCAN) && (!out_valid || !out_stall);
  end

  assign take_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the input transaction
  always_ff @(posedge clk) begin
    if (take_in) begin
      item_mode    <= mode;
      item.tag     <= tag;
      item.weight  <= weight;
      item.mask    <= resource_mask;
      item.light   <= light;
      item.total   <= total_phases;
      item.phase   <= phase;
    end
  end

  // command broadcast to the cell row
  always_comb begin
    flush     = (count != '0) && slots[0].light;
    full      = (count == CNT_W'(QUEUE_DEPTH)) && !flush;
    cmd.ins   = upd && !item_mode && !full;
    cmd.fb    = upd && item_mode;
    cmd.flush = flush;
    cmd.amask = AMASK;
    cmd.item  = item;
  end

  always_comb begin
    chains[0].ge   = 1'b1;
    chains[0].seen = 1'b0;
    chains[0].rm   = 1'b0;
    chains[0].run  = 1'b1;
    chains[0].used = '0;
  end

  // row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left_s;
    slot_t right_s;

    assign occ[i] = (count > CNT_W'(i));
    assign ld[i]  = flags[i].load;

    if (i == 0) begin : g_first
      assign left_s = item;
    end else begin : g_mid_l
      assign left_s = slots[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_s = slots[i];
    end else begin : g_mid_r
      assign right_s = slots[i+1];
    end

    wqri_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[i]),
      .left      (left_s),
      .right     (right_s),
      .chain_in  (chains[i]),
      .chain_out (chains[i+1]),
      .slot      (slots[i]),
      .flags     (flags[i])
    );
  end

  // collect cell flags
  always_comb begin
    logic nxt_run;
    any_hit  = 1'b0;
    any_ok   = 1'b0;
    any_done = 1'b0;
    ins_pos  = '0;
    par_cnt  = '0;
    owner_any = '0;
    for (int a = 0; a < MASK_W; a++) begin
      owner_or[a] = '0;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      nxt_run  = (i == QUEUE_DEPTH - 1) ? 1'b0 : flags[(i + 1) % QUEUE_DEPTH].run;
      any_hit  = any_hit | flags[i].hit;
      any_ok   = any_ok | flags[i].ok;
      any_done = any_done | flags[i].done;
      ins_pos  = ins_pos | (flags[i].load ? POS_W'(i + 1) : '0);
      par_cnt  = par_cnt | ((flags[i].run && !nxt_run) ? POS_W'(i + 1) : '0);
      for (int a = 0; a < MASK_W; a++) begin
        if (flags[i].run && flags[i].mask[a]) begin
          owner_or[a]  = owner_or[a] | POS_W'(i + 1);
          owner_any[a] = 1'b1;
        end
      end
    end
    for (int a = 0; a < MASK_W; a++) begin
      owner[a] = owner_any[a] ? owner_or[a] : POS_W'(1);
    end
  end

  // occupancy count
  always_comb begin
    count_next = count;
    if (upd) begin
      if (!item_mode) begin
        if (!full) begin
          count_next = (flush ? '0 : count) + CNT_W'(1);
        end
      end else if (any_done) begin
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // status of the update pass, held for the scan
  always_ff @(posedge clk) begin
    if (upd) begin
      if (!item_mode) begin
        pend_status <= full ? STAT_FULL : STAT_INSERTED;
        pend_pos    <= full ? '0 : ins_pos;
      end else begin
        pend_pos <= '0;
        if (!any_hit) begin
          pend_status <= STAT_ABSENT;
        end else if (!any_ok) begin
          pend_status <= STAT_WRONG_PHASE;
        end else if (any_done) begin
          pend_status <= STAT_COMPLETED;
        end else begin
          pend_status <= STAT_ADVANCED;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status            <= pend_status;
      insert_position   <= pend_pos;
      parallel_count    <= par_cnt;
      owner_gaze        <= owner[0];
      owner_emotion     <= owner[1];
      owner_voice       <= owner[2];
      owner_manipulator <= owner[3];
      owner_mover       <= owner[4];
      queue_empty       <= (count == '0);
    end
  end

  // checks
  `WQRI_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(QUEUE_DEPTH))
  `WQRI_ASSERT_IMP(a_single_load, clk, rst, upd, $onehot0(ld))
  `WQRI_ASSERT_IMP(a_empty_run, clk, rst, out_valid && queue_empty, parallel_count == '0)
  `WQRI_ASSERT_NEXT(a_update_scan, clk, rst, state == S_UPDATE, state == S_SCAN)

endmodule

FILE: hdl/wqri_cell.sv
// ----------------------------------------------------------------------------
// wqri_cell
// one queue slot: insert-by-weight shift, tag match, removal shift and
// one step of the conflict scan
// ----------------------------------------------------------------------------
module wqri_cell (
  input  logic             clk,
  input  wqri_pkg::cmd_t   cmd,
  input  logic             occ,
  input  wqri_pkg::slot_t  left,
  input  wqri_pkg::slot_t  right,
  input  wqri_pkg::chain_t chain_in,
  output wqri_pkg::chain_t chain_out,
  output wqri_pkg::slot_t  slot,
  output wqri_pkg::flags_t flags
);
  import wqri_pkg::*;

  slot_t             slot_next;
  slot_t             fresh;
  logic              ge;
  logic              match;
  logic              hit;
  logic              ok;
  logic              done;
  logic              rm;
  logic              run;
  logic [MASK_W-1:0] m;

  // local compares against the broadcast item
  always_comb begin
    ge    = occ && !cmd.flush && (slot.weight >= cmd.item.weight);
    match = occ && (slot.tag == cmd.item.tag);
    hit   = match && !chain_in.seen;
    ok    = hit && (cmd.item.phase > slot.phase) && (cmd.item.phase <= slot.total);
    done  = ok && (cmd.item.phase == slot.total);
    rm    = chain_in.rm | done;
    m     = slot.mask & cmd.amask;
    run   = chain_in.run && occ && ((m & chain_in.used) == '0);
  end

  // hand-off to the right neighbor
  always_comb begin
    chain_out.ge   = ge;
    chain_out.seen = chain_in.seen | match;
    chain_out.rm   = rm;
    chain_out.run  = run;
    chain_out.used = chain_in.used | (run ? m : '0);
  end

  always_comb begin
    flags.load = cmd.ins && !ge && chain_in.ge;
    flags.hit  = hit;
    flags.ok   = ok;
    flags.done = done;
    flags.run  = run;
    flags.mask = m;
  end

  // next slot contents
  always_comb begin
    fresh       = cmd.item;
    fresh.phase = '0;
    slot_next   = slot;
    if (cmd.ins) begin
      if (!ge) begin
        slot_next = chain_in.ge ? fresh : left;
      end
    end else if (cmd.fb) begin
      if (rm) begin
        slot_next = right;
      end else if (ok) begin
        slot_next.phase = cmd.item.phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the weighted task queue with actuator conflict scan
// ----------------------------------------------------------------------------
// Directed transactions cover the light-head flush, ordering by weight, every
// feedback outcome and the full queue. Random traffic then follows, its
// feedback mostly well-formed and on queued tags. A predictor built into the bench
// tracks the queue contents. Every result is compared field by field with
// the oldest predicted outcome. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wqri_pkg::*;

  localparam int DEPTH       = 16;
  localparam int IDLE_LIMIT  = 2000;
  localparam logic MODE_INSERT   = 1'b0;
  localparam logic MODE_FEEDBACK = 1'b1;

  // predicted result of one transaction
  typedef struct {
    status_t                         status;
    logic [POS_W-1:0]                position;
    logic [POS_W-1:0]                run_len;
    logic [MASK_W-1:0][POS_W-1:0]    owner;
    logic                            empty;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid;
  logic                 in_stall;
  logic                 mode;
  logic [TAG_W-1:0]     tag;
  logic [WEIGHT_W-1:0]  weight;
  logic [MASK_W-1:0]    resource_mask;
  logic                 light;
  logic [PHASE_W-1:0]   total_phases;
  logic [PHASE_W-1:0]   phase;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  status;
  logic [POS_W-1:0]     insert_position;
  logic [POS_W-1:0]     parallel_count;
  logic [POS_W-1:0]     owner_gaze;
  logic [POS_W-1:0]     owner_emotion;
  logic [POS_W-1:0]     owner_voice;
  logic [POS_W-1:0]     owner_manipulator;
  logic [POS_W-1:0]     owner_mover;
  logic                 queue_empty;

  // predicted queue contents
  slot_t    task_slots [DEPTH];
  int       task_count = 0;
  outcome_t pending_outcomes [$];
  int       errors = 0;
  bit       idle_on = 1'b1;
  int       quiet_cycles = 0;

  weighted_queue_resource_issue i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .mode              (mode),
    .tag               (tag),
    .weight            (weight),
    .resource_mask     (resource_mask),
    .light             (light),
    .total_phases      (total_phases),
    .phase             (phase),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .insert_position   (insert_position),
    .parallel_count    (parallel_count),
    .owner_gaze        (owner_gaze),
    .owner_emotion     (owner_emotion),
    .owner_voice       (owner_voice),
    .owner_manipulator (owner_manipulator),
    .owner_mover       (owner_mover),
    .queue_empty       (queue_empty)
  );

  always #6 clk = ~clk;

  // queue update and conflict scan for one accepted transaction
  function automatic outcome_t predict_event(logic m, logic [TAG_W-1:0] t,
                                             logic [WEIGHT_W-1:0] w,
                                             logic [MASK_W-1:0] mk, logic lt,
                                             logic [PHASE_W-1:0] tot,
                                             logic [PHASE_W-1:0] ph);
    outcome_t          res;
    int                pos;
    int                k;
    int                a;
    int                run;
    logic [MASK_W-1:0] busy;
    logic [MASK_W-1:0] cur;
    res.position = '0;
    if (m == MODE_INSERT) begin
      // a light head flushes the whole queue
      if (task_count > 0 && task_slots[0].light) task_count = 0;
      if (task_count >= DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        pos = 0;
        while (pos < task_count && task_slots[pos].weight >= w) pos++;
        for (k = task_count; k > pos; k--) task_slots[k] = task_slots[k-1];
        task_slots[pos].tag    = t;
        task_slots[pos].weight = w;
        task_slots[pos].mask   = mk;
        task_slots[pos].light  = lt;
        task_slots[pos].total  = tot;
        task_slots[pos].phase  = '0;
        task_count++;
        res.status   = STAT_INSERTED;
        res.position = POS_W'(pos + 1);
      end
    end else begin
      // first task with a matching tag only
      k = 0;
      while (k < task_count && task_slots[k].tag != t) k++;
      if (k == task_count) begin
        res.status = STAT_ABSENT;
      end else if (!(ph > task_slots[k].phase && ph <= task_slots[k].total)) begin
        res.status = STAT_WRONG_PHASE;
      end else begin
        task_slots[k].phase = ph;
        if (ph == task_slots[k].total) begin
          for (pos = k; pos + 1 < task_count; pos++) task_slots[pos] = task_slots[pos+1];
          task_count--;
          res.status = STAT_COMPLETED;
        end else begin
          res.status = STAT_ADVANCED;
        end
      end
    end
    // leading run of tasks with disjoint masks
    busy = '0;
    run  = 0;
    for (a = 0; a < MASK_W; a++) res.owner[a] = POS_W'(1);
    for (k = 0; k < task_count; k++) begin
      cur = task_slots[k].mask;
      if ((cur & busy) != '0) break;
      busy |= cur;
      run++;
      for (a = 0; a < MASK_W; a++)
        if (cur[a]) res.owner[a] = POS_W'(run);
    end
    res.run_len = POS_W'(run);
    res.empty   = (task_count == 0);
    return res;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // drive one transaction and hold it until accepted
  task automatic send_event(input logic m, input logic [TAG_W-1:0] t,
                            input logic [WEIGHT_W-1:0] w,
                            input logic [MASK_W-1:0] mk, input logic lt,
                            input logic [PHASE_W-1:0] tot,
                            input logic [PHASE_W-1:0] ph);
    int       gap;
    logic     grab;
    outcome_t predicted;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    tag           <= t;
    weight        <= w;
    resource_mask <= mk;
    light         <= lt;
    total_phases  <= tot;
    phase         <= ph;
    do begin
      @(negedge clk);
      grab = !in_stall;
      @(posedge clk);
    end while (!grab);
    predicted = predict_event(m, t, w, mk, lt, tot, ph);
    pending_outcomes.insert(pending_outcomes.size(), predicted);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // light head is flushed by the next insert
  task automatic test_light_flush();
    send_event(MODE_INSERT, 8'd9, 16'h0100, 5'b00100, 1'b1, 4'd3, 4'd0);
    send_event(MODE_INSERT, 8'd10, 16'h0050, 5'b01000, 1'b0, 4'd4, 4'd15);
  endtask

  // descending weight, equal weights in arrival order, empty mask, zero total
  task automatic test_insert_order();
    send_event(MODE_INSERT, 8'd1, 16'h8000, 5'b00001, 1'b0, 4'd2, 4'd0);
    send_event(MODE_INSERT, 8'd2, 16'h8000, 5'b00010, 1'b0, 4'd15, 4'd0);
    send_event(MODE_INSERT, 8'd255, 16'hFFFF, 5'b11111, 1'b0, 4'd1, 4'd0);
    send_event(MODE_INSERT, 8'd0, 16'h0000, 5'b00000, 1'b0, 4'd0, 4'd0);
  endtask

  // every feedback outcome
  task automatic test_phase_feedback();
    send_event(MODE_FEEDBACK, 8'd77, 16'h1234, 5'b10101, 1'b1, 4'd7, 4'd1);
    send_event(MODE_FEEDBACK, 8'd1, 16'h0000, 5'b00000, 1'b0, 4'd0, 4'd0);
    send_event(MODE_FEEDBACK, 8'd1, 16'h0000, 5'b00000, 1'b0, 4'd0, 4'd3);
    send_event(MODE_FEEDBACK, 8'd1, 16'h0000, 5'b00000, 1'b0, 4'd0, 4'd1);
    send_event(MODE_FEEDBACK, 8'd1, 16'h0000, 5'b00000, 1'b0, 4'd0, 4'd2);
    send_event(MODE_FEEDBACK, 8'd0, 16'hFFFF, 5'b11111, 1'b0, 4'd15, 4'd15);
    send_event(MODE_FEEDBACK, 8'd255, 16'h0000, 5'b00000, 1'b0, 4'd0, 4'd1);
  endtask

  // fill the queue, then one insert more is rejected
  task automatic test_full_queue();
    while (task_count < DEPTH)
      send_event(MODE_INSERT, 8'($urandom_range(100, 120)), 16'($urandom_range(0, 65535)),
                 5'(1 << $urandom_range(0, 4)), 1'b0, 4'($urandom_range(1, 15)), 4'd0);
    send_event(MODE_INSERT, 8'd200, 16'hFFFF, 5'b00001, 1'b0, 4'd5, 4'd0);
  endtask

  // sender holds off until every result is back
  task automatic test_pause_until_drained();
    wait_until_drained();
  endtask

  // random traffic, feedback mostly on queued tags
  task automatic test_random_traffic(input int count);
    int                  i;
    int                  k;
    int                  pick;
    logic                m;
    logic [TAG_W-1:0]    t;
    logic [WEIGHT_W-1:0] w;
    logic [MASK_W-1:0]   mk;
    logic                lt;
    logic [PHASE_W-1:0]  tot;
    logic [PHASE_W-1:0]  ph;
    for (i = 0; i < count; i++) begin
      if (i % 250 == 0) idle_on = ($urandom_range(0, 3) != 0);
      t   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
      pick = $urandom_range(0, 3);
      w   = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
            (pick == 2) ? 16'(16'h0100 * $urandom_range(0, 7)) : 16'($urandom_range(0, 65535));
      mk  = ($urandom_range(0, 2) == 0) ? 5'(1 << $urandom_range(0, 4)) : 5'($urandom_range(0, 31));
      lt  = ($urandom_range(0, 9) == 0);
      tot = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(1, 15));
      ph  = 4'($urandom_range(0, 15));
      m   = ($urandom_range(0, 99) < 55) ? MODE_INSERT : MODE_FEEDBACK;
      if (m == MODE_FEEDBACK && task_count > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, task_count - 1);
        t = task_slots[k].tag;
        pick = $urandom_range(0, 2);
        if (pick == 0) ph = task_slots[k].total;
        else if (pick == 1) ph = task_slots[k].phase + 4'd1;
      end
      send_event(m, t, w, mk, lt, tot, ph);
    end
  endtask

  // result side: random stall, compare each transaction
  initial begin
    int               n;
    logic             got;
    outcome_t         want;
    logic [STATUS_W-1:0] s_status;
    logic [POS_W-1:0] s_pos;
    logic [POS_W-1:0] s_run;
    logic [POS_W-1:0] s_gaze;
    logic [POS_W-1:0] s_emotion;
    logic [POS_W-1:0] s_voice;
    logic [POS_W-1:0] s_manip;
    logic [POS_W-1:0] s_mover;
    logic             s_empty;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    forever begin
      n = idle_on ? $urandom_range(0, 9) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got       = out_valid && !out_stall;
        s_status  = status;
        s_pos     = insert_position;
        s_run     = parallel_count;
        s_gaze    = owner_gaze;
        s_emotion = owner_emotion;
        s_voice   = owner_voice;
        s_manip   = owner_manipulator;
        s_mover   = owner_mover;
        s_empty   = queue_empty;
        @(posedge clk);
      end while (!got);
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result transaction with nothing outstanding", $time);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        compare_field("status", 16'(want.status), 16'(s_status));
        compare_field("insert_position", 16'(want.position), 16'(s_pos));
        compare_field("parallel_count", 16'(want.run_len), 16'(s_run));
        compare_field("owner_gaze", 16'(want.owner[0]), 16'(s_gaze));
        compare_field("owner_emotion", 16'(want.owner[1]), 16'(s_emotion));
        compare_field("owner_voice", 16'(want.owner[2]), 16'(s_voice));
        compare_field("owner_manipulator", 16'(want.owner[3]), 16'(s_manip));
        compare_field("owner_mover", 16'(want.owner[4]), 16'(s_mover));
        compare_field("queue_empty", 16'(want.empty), 16'(s_empty));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(negedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // test sequence
  initial begin
    in_valid      = 1'b0;
    mode          = MODE_INSERT;
    tag           = '0;
    weight        = '0;
    resource_mask = '0;
    light         = 1'b0;
    total_phases  = '0;
    phase         = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_light_flush();
    test_insert_order();
    test_phase_feedback();
    test_full_queue();
    test_pause_until_drained();
    test_random_traffic(1000);
    test_pause_until_drained();
    test_random_traffic(1000);
    wait_until_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
